/* rtl/wsp_pkg.sv */
package wsp_pkg;

    // Number formats
    localparam int FRAC_BITS = 16;
    localparam int UNIT_BITS = 30;
    localparam int TAN_FRAC  = 16;
    localparam int TAN_W     = 24;
    localparam int DIM_W     = 16;
    localparam int COORD_W   = 32;
    localparam int QUO_W     = 40;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int RSHR_IN_W = 68;
    localparam int RSHR_OUT_W = 38;

    // Near plane depth, rounded to the coordinate format
    localparam longint NEAR_VAL = ((longint'(1) << FRAC_BITS) + 5) / 10;

    typedef enum logic [1:0] {
        STAT_VISIBLE = 2'd0,
        STAT_NEAR    = 2'd1,
        STAT_DEGEN   = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_ORIGIN_Z    = 3'd2,
        CFG_AXIS_X      = 3'd3,
        CFG_AXIS_Y      = 3'd4,
        CFG_AXIS_Z      = 3'd5,
        CFG_TAN_HALF    = 3'd6,
        CFG_SCREEN_DIMS = 3'd7
    } cfg_idx_t;

    // Camera basis, signed Q2.30 unit vectors
    typedef struct packed {
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic signed [COORD_W-1:0] fz;
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
        logic signed [COORD_W-1:0] ux;
        logic signed [COORD_W-1:0] uy;
        logic signed [COORD_W-1:0] uz;
    } basis_t;

    // Shift right by the unit fraction, rounding halves away from zero
    function automatic logic signed [RSHR_OUT_W-1:0] rshr_unit(
        input logic signed [RSHR_IN_W-1:0] v
    );
        logic [RSHR_IN_W-1:0] mag;
        logic [RSHR_IN_W-1:0] rnd;
        mag = v[RSHR_IN_W-1] ? RSHR_IN_W'(-v) : RSHR_IN_W'(v);
        rnd = (mag + (RSHR_IN_W'(1) << (UNIT_BITS - 1))) >> UNIT_BITS;
        return v[RSHR_IN_W-1] ? $signed(-RSHR_OUT_W'(rnd)) : $signed(RSHR_OUT_W'(rnd));
    endfunction

endpackage

/* rtl/wsp_basis.sv */
module wsp_basis
    import wsp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] axis_x,
    input  logic signed [COORD_W-1:0] axis_y,
    input  logic signed [COORD_W-1:0] axis_z,
    output logic                      busy,
    output basis_t                    basis
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LOAD  = 8'b0000_0010,
        ST_NORM  = 8'b0000_0100,
        ST_SQR   = 8'b0000_1000,
        ST_ROOT  = 8'b0001_0000,
        ST_DIVI  = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_CROSS = 8'b1000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic                       right_sel_reg;
    logic [1:0]                 idx_reg;
    logic [4:0]                 cnt_reg;
    logic [2:0][COORD_W-1:0]    mag_reg;
    logic [2:0]                 neg_reg;
    logic [COORD_W-1:0]         max_reg;
    logic [63:0]                acc_reg;
    logic [63:0]                res_reg;
    logic [COORD_W-1:0]         rem_reg;
    logic [63:0]                num_reg;
    logic [COORD_W-1:0]         quo_reg;
    logic signed [63:0]         prod_reg;
    basis_t                     basis_reg;

    logic signed [COORD_W:0]    comp [0:2];
    logic [2:0][COORD_W-1:0]    cmag;
    logic [2:0]                 cneg;
    logic [COORD_W-1:0]         cmax;
    logic                       degen;
    logic [63:0]                sq_term;
    logic [63:0]                bit_val;
    logic [63:0]                trial;
    logic [63:0]                nval;
    logic [COORD_W:0]           rem_sh;
    logic [COORD_W:0]           root33;
    logic                       dge;
    logic [COORD_W-1:0]         quo_new;
    logic signed [COORD_W-1:0]  unit_val;
    logic signed [COORD_W-1:0]  mul_a, mul_b;
    logic signed [63:0]         mul_p;

    assign degen = (axis_x == '0) && (axis_y == '0);

    // Select the vector being normalized: forward axis, or right = (y, -x, 0)
    always_comb begin
        if (right_sel_reg) begin
            comp[0] = (COORD_W+1)'(axis_y);
            comp[1] = -(COORD_W+1)'(axis_x);
            comp[2] = '0;
        end else begin
            comp[0] = (COORD_W+1)'(axis_x);
            comp[1] = (COORD_W+1)'(axis_y);
            comp[2] = (COORD_W+1)'(axis_z);
        end
        for (int i = 0; i < 3; i++) begin
            cneg[i] = comp[i][COORD_W];
            cmag[i] = COORD_W'(comp[i][COORD_W] ? -comp[i] : comp[i]);
        end
        cmax = cmag[0];
        if (cmag[1] > cmax) cmax = cmag[1];
        if (cmag[2] > cmax) cmax = cmag[2];
    end

    // Shared arithmetic of the sequencer
    assign sq_term  = 64'(mag_reg[idx_reg]) * 64'(mag_reg[idx_reg]);
    assign bit_val  = 64'd1 << {cnt_reg, 1'b0};
    assign trial    = res_reg + bit_val;
    assign nval     = ({32'd0, mag_reg[idx_reg]} << UNIT_BITS) + (res_reg >> 1);
    assign rem_sh   = {rem_reg, num_reg[cnt_reg]};
    assign root33   = {1'b0, res_reg[COORD_W-1:0]};
    assign dge      = rem_sh >= root33;
    assign quo_new  = {quo_reg[COORD_W-2:0], dge};
    assign unit_val = neg_reg[idx_reg] ? $signed(-quo_new) : $signed(quo_new);

    // Cross product operands, one product per step
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    begin mul_a = basis_reg.rx; mul_b = basis_reg.fy; end
            2'd1:    begin mul_a = basis_reg.ry; mul_b = basis_reg.fx; end
            2'd2:    begin mul_a = basis_reg.ry; mul_b = basis_reg.fz; end
            default: begin mul_a = basis_reg.rx; mul_b = basis_reg.fz; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Sequencer control
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = ST_IDLE;
            ST_LOAD:  state_next = degen ? ST_IDLE : ST_NORM;
            ST_NORM:  if (max_reg[COORD_W-1:COORD_W-2] != 2'b00) state_next = ST_SQR;
            ST_SQR:   if (idx_reg == 2'd2) state_next = ST_ROOT;
            ST_ROOT:  if (cnt_reg == 5'd0) state_next = ST_DIVI;
            ST_DIVI:  state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == 5'd0) begin
                    if (right_sel_reg && idx_reg == 2'd1) state_next = ST_CROSS;
                    else if (idx_reg == 2'd2)             state_next = ST_LOAD;
                    else                                   state_next = ST_DIVI;
                end
            end
            ST_CROSS: if (cnt_reg == 5'd3) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
        if (start) state_next = ST_LOAD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            right_sel_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (start) begin
                right_sel_reg <= 1'b0;
            end else if (state_reg == ST_DIV && cnt_reg == 5'd0 && !right_sel_reg
                         && idx_reg == 2'd2) begin
                right_sel_reg <= 1'b1;
            end
        end
    end

    // Datapath: normalize, sum squares, root, divide, cross
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_LOAD: begin
                mag_reg <= cmag;
                neg_reg <= cneg;
                max_reg <= cmax;
            end
            ST_NORM: begin
                if (max_reg[COORD_W-1:COORD_W-2] == 2'b00) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                    max_reg <= max_reg << 1;
                end
                idx_reg <= 2'd0;
                acc_reg <= '0;
            end
            ST_SQR: begin
                acc_reg <= acc_reg + sq_term;
                idx_reg <= idx_reg + 2'd1;
                if (idx_reg == 2'd2) begin
                    idx_reg <= 2'd0;
                    res_reg <= '0;
                    cnt_reg <= 5'd31;
                end
            end
            ST_ROOT: begin
                if (acc_reg >= trial) begin
                    acc_reg <= acc_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_val;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            ST_DIVI: begin
                rem_reg <= nval[63:32];
                num_reg <= nval;
                quo_reg <= '0;
                cnt_reg <= 5'd31;
            end
            ST_DIV: begin
                rem_reg <= dge ? COORD_W'(rem_sh - root33) : rem_sh[COORD_W-1:0];
                quo_reg <= quo_new;
                if (cnt_reg == 5'd0) begin
                    idx_reg <= idx_reg + 2'd1;
                    if (right_sel_reg) begin
                        if (idx_reg == 2'd0) basis_reg.rx <= unit_val;
                        else                 basis_reg.ry <= unit_val;
                    end else begin
                        case (idx_reg)
                            2'd0:    basis_reg.fx <= unit_val;
                            2'd1:    basis_reg.fy <= unit_val;
                            default: basis_reg.fz <= unit_val;
                        endcase
                    end
                end else begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
            ST_CROSS: begin
                cnt_reg <= cnt_reg + 5'd1;
                case (cnt_reg[1:0])
                    2'd0: prod_reg <= mul_p;
                    2'd1: basis_reg.uz <=
                        COORD_W'(rshr_unit(RSHR_IN_W'(prod_reg) - RSHR_IN_W'(mul_p)));
                    2'd2: basis_reg.ux <= COORD_W'(rshr_unit(RSHR_IN_W'(mul_p)));
                    default: basis_reg.uy <= COORD_W'(-rshr_unit(RSHR_IN_W'(mul_p)));
                endcase
            end
            default: ;
        endcase
    end

    assign busy  = (state_reg != ST_IDLE);
    assign basis = basis_reg;

endmodule

/* rtl/world_to_screen_projection_top.sv */
// Perspective projection of world points to screen pixels, signed Q16.16 in and out.
// One point is taken per cycle unless the output stalls or the basis is rebuilt;
// the depth divide is a 40-stage restoring divider, one quotient bit per stage.
// The camera basis is rebuilt by a shared multi-cycle unit (normalize, integer
// square root, bit-serial divide, cross product) after reset and after every
// write to an axis register, and s_tready stays low meanwhile. Other registers
// take effect at once. status on m_tuser: 0 visible, 1 nearer than the near plane,
// 2 vertical or zero view axis.
module world_to_screen_projection_top
    import wsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [95:0]           s_tdata,    // point_x, point_y, point_z
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,    // screen_x, screen_y
    output logic [1:0]            m_tuser,    // status
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int L_W    = COORD_W + 1;
    localparam int P_W    = L_W + COORD_W;
    localparam int NX_W   = COORD_W + 4;
    localparam int MAG_W  = NX_W - 1;
    localparam int DEN_W  = TAN_W + MAG_W;
    localparam int NUMP_W = DIM_W + MAG_W;
    localparam int NSHIFT = FRAC_BITS - 1 + TAN_FRAC;
    localparam int NUM_W  = NUMP_W + NSHIFT;
    localparam int CEN_W  = DIM_W + FRAC_BITS - 1;
    localparam int SUM_W  = QUO_W + 3;
    localparam logic [QUO_W:0] LIMIT = (QUO_W+1)'(1) << QUO_W;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(32'sh8000_0000);
    localparam logic signed [NX_W-1:0]  NEAR   = NX_W'(NEAR_VAL);

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] num_lo;
        logic [QUO_W-1:0] quo;
        logic             ovf;
        logic             zero;
        logic             tanz;
        logic             neg;
    } div_t;

    typedef struct packed {
        logic [1:0] status;
        div_t       x;
        div_t       y;
    } dpipe_t;

    // One restoring step: bring down a numerator bit, subtract when it fits
    function automatic div_t div_step(input div_t d);
        div_t           o;
        logic [DEN_W:0] sh;
        logic           ge;
        o        = d;
        sh       = {d.rem, d.num_lo[QUO_W-1]};
        ge       = sh >= {1'b0, d.den};
        o.rem    = ge ? DEN_W'(sh - {1'b0, d.den}) : sh[DEN_W-1:0];
        o.num_lo = d.num_lo << 1;
        o.quo    = {d.quo[QUO_W-2:0], ge};
        return o;
    endfunction

    // Set up the divider; flag quotients that reach the offset limit
    function automatic div_t div_init(input logic [NUMP_W-1:0] p, input logic [DEN_W-1:0] den,
                                      input logic zero, input logic tanz, input logic neg);
        div_t             o;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] hi;
        num      = NUM_W'(p) << NSHIFT;
        hi       = num >> QUO_W;
        o.ovf    = hi >= NUM_W'(den);
        o.rem    = DEN_W'(hi);
        o.den    = den;
        o.num_lo = num[QUO_W-1:0];
        o.quo    = '0;
        o.zero   = zero;
        o.tanz   = tanz;
        o.neg    = neg;
        return o;
    endfunction

    // Round, clamp, place about the centre and saturate
    function automatic logic [COORD_W-1:0] place(input div_t d, input logic [CEN_W-1:0] cen);
        logic [QUO_W:0]           q;
        logic                     rnd;
        logic signed [SUM_W-1:0]  s;
        rnd = {d.rem, 1'b0} >= {1'b0, d.den};
        if (d.zero)                q = '0;
        else if (d.tanz || d.ovf)  q = LIMIT;
        else                       q = {1'b0, d.quo} + (QUO_W+1)'(rnd);
        s = d.neg ? $signed(SUM_W'(cen)) - $signed(SUM_W'(q))
                  : $signed(SUM_W'(cen)) + $signed(SUM_W'(q));
        if (s > SAT_HI) s = SAT_HI;
        if (s < SAT_LO) s = SAT_LO;
        return COORD_W'(s);
    endfunction

    // Configuration registers
    logic signed [COORD_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [COORD_W-1:0] axis_x_reg, axis_y_reg, axis_z_reg;
    logic [2*TAN_W-1:0]        tan_reg;
    logic [2*DIM_W-1:0]        dims_reg;
    logic                      recalc_reg;
    logic                      basis_busy;
    basis_t                    basis;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            axis_x_reg   <= 32'sh0001_0000;
            axis_y_reg   <= '0;
            axis_z_reg   <= '0;
            tan_reg      <= 48'h0001_0001_0000;
            dims_reg     <= 32'h0780_0438;
            recalc_reg   <= 1'b1;
        end else begin
            recalc_reg <= cfg_wr_en && (cfg_index == CFG_AXIS_X || cfg_index == CFG_AXIS_Y
                                        || cfg_index == CFG_AXIS_Z);
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ORIGIN_X:    origin_x_reg <= cfg_data[COORD_W-1:0];
                    CFG_ORIGIN_Y:    origin_y_reg <= cfg_data[COORD_W-1:0];
                    CFG_ORIGIN_Z:    origin_z_reg <= cfg_data[COORD_W-1:0];
                    CFG_AXIS_X:      axis_x_reg   <= cfg_data[COORD_W-1:0];
                    CFG_AXIS_Y:      axis_y_reg   <= cfg_data[COORD_W-1:0];
                    CFG_AXIS_Z:      axis_z_reg   <= cfg_data[COORD_W-1:0];
                    CFG_TAN_HALF:    tan_reg      <= cfg_data[2*TAN_W-1:0];
                    CFG_SCREEN_DIMS: dims_reg     <= cfg_data[2*DIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    wsp_basis u_basis (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (recalc_reg),
        .axis_x  (axis_x_reg),
        .axis_y  (axis_y_reg),
        .axis_z  (axis_z_reg),
        .busy    (basis_busy),
        .basis   (basis)
    );

    // Pipeline control: all stages advance together when the output frees; stage 0 also loads while empty
    logic                      adv;
    logic                      accept;
    logic [4:0]                front_vld_reg;
    logic [QUO_W:0]            div_vld_reg;
    logic                      m_tvalid_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = !basis_busy && !recalc_reg && (adv || !front_vld_reg[0]);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_vld_reg <= '0;
            div_vld_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (adv || !front_vld_reg[0]) front_vld_reg[0] <= accept;
            if (adv) begin
                front_vld_reg[4:1] <= front_vld_reg[3:0];
                div_vld_reg        <= {div_vld_reg[QUO_W-1:0], front_vld_reg[4]};
                m_tvalid_reg       <= div_vld_reg[QUO_W];
            end
        end
    end

    // Stage 0: hold the request
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg <= s_tdata[31:0];
            py_reg <= s_tdata[63:32];
            pz_reg <= s_tdata[95:64];
        end
    end

    // Stage 1: offset from the camera origin
    logic signed [L_W-1:0] lx_reg, ly_reg, lz_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            lx_reg <= L_W'(px_reg) - L_W'(origin_x_reg);
            ly_reg <= L_W'(py_reg) - L_W'(origin_y_reg);
            lz_reg <= L_W'(pz_reg) - L_W'(origin_z_reg);
        end
    end

    // Stage 2: products against the basis
    logic signed [P_W-1:0] prod_reg [0:7];
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg[0] <= lx_reg * basis.rx;
            prod_reg[1] <= ly_reg * basis.ry;
            prod_reg[2] <= lx_reg * basis.ux;
            prod_reg[3] <= ly_reg * basis.uy;
            prod_reg[4] <= lz_reg * basis.uz;
            prod_reg[5] <= lx_reg * basis.fx;
            prod_reg[6] <= ly_reg * basis.fy;
            prod_reg[7] <= lz_reg * basis.fz;
        end
    end

    // Stage 3: sum and round to camera coordinates
    logic signed [NX_W-1:0] nx_reg, ny_reg, nz_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg <= NX_W'(rshr_unit(RSHR_IN_W'(prod_reg[0]) + RSHR_IN_W'(prod_reg[1])));
            ny_reg <= NX_W'(rshr_unit(RSHR_IN_W'(prod_reg[2]) + RSHR_IN_W'(prod_reg[3])
                                      + RSHR_IN_W'(prod_reg[4])));
            nz_reg <= NX_W'(rshr_unit(RSHR_IN_W'(prod_reg[5]) + RSHR_IN_W'(prod_reg[6])
                                      + RSHR_IN_W'(prod_reg[7])));
        end
    end

    // Stage 4: classify, form numerators and divisors
    logic [MAG_W-1:0]  magx, magy, zdep;
    logic [NUMP_W-1:0] numx_reg, numy_reg;
    logic [DEN_W-1:0]  denx_reg, deny_reg;
    logic [1:0]        stat4_reg;
    logic              zx_reg, zy_reg, negx_reg, negy_reg, tanzx_reg, tanzy_reg;

    assign magx = MAG_W'(nx_reg[NX_W-1] ? -nx_reg : nx_reg);
    assign magy = MAG_W'(ny_reg[NX_W-1] ? -ny_reg : ny_reg);
    assign zdep = nz_reg[MAG_W-1:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            numx_reg  <= NUMP_W'(dims_reg[2*DIM_W-1:DIM_W]) * NUMP_W'(magx);
            numy_reg  <= NUMP_W'(dims_reg[DIM_W-1:0]) * NUMP_W'(magy);
            denx_reg  <= DEN_W'(tan_reg[2*TAN_W-1:TAN_W]) * DEN_W'(zdep);
            deny_reg  <= DEN_W'(tan_reg[TAN_W-1:0]) * DEN_W'(zdep);
            zx_reg    <= (nx_reg == '0);
            zy_reg    <= (ny_reg == '0);
            negx_reg  <= nx_reg[NX_W-1];
            negy_reg  <= !ny_reg[NX_W-1];
            tanzx_reg <= (tan_reg[2*TAN_W-1:TAN_W] == '0);
            tanzy_reg <= (tan_reg[TAN_W-1:0] == '0);
            if (axis_x_reg == '0 && axis_y_reg == '0) stat4_reg <= STAT_DEGEN;
            else if (nz_reg < NEAR)                    stat4_reg <= STAT_NEAR;
            else                                       stat4_reg <= STAT_VISIBLE;
        end
    end

    // Divider stages: setup, then one quotient bit per stage
    dpipe_t div_reg [0:QUO_W];
    always_ff @(posedge aclk) begin
        if (adv) begin
            div_reg[0].status <= stat4_reg;
            div_reg[0].x <= div_init(numx_reg, denx_reg, zx_reg, tanzx_reg, negx_reg);
            div_reg[0].y <= div_init(numy_reg, deny_reg, zy_reg, tanzy_reg, negy_reg);
            for (int k = 1; k <= QUO_W; k++) begin
                div_reg[k].status <= div_reg[k-1].status;
                div_reg[k].x      <= div_step(div_reg[k-1].x);
                div_reg[k].y      <= div_step(div_reg[k-1].y);
            end
        end
    end

    // Output stage: place on screen, zero rejected points
    logic [COORD_W-1:0] sx_reg, sy_reg;
    logic [1:0]         stat_reg;
    logic [CEN_W-1:0]   cen_x, cen_y;

    assign cen_x = CEN_W'(dims_reg[2*DIM_W-1:DIM_W]) << (FRAC_BITS - 1);
    assign cen_y = CEN_W'(dims_reg[DIM_W-1:0]) << (FRAC_BITS - 1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            stat_reg <= div_reg[QUO_W].status;
            if (div_reg[QUO_W].status == STAT_VISIBLE) begin
                sx_reg <= place(div_reg[QUO_W].x, cen_x);
                sy_reg <= place(div_reg[QUO_W].y, cen_y);
            end else begin
                sx_reg <= '0;
                sy_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {sy_reg, sx_reg};
    assign m_tuser  = stat_reg;

endmodule

/* dv/world_to_screen_projection_top_tb.sv */
`timescale 1ns / 100ps

module world_to_screen_projection_top_tb;
    import wsp_pkg::*;

    localparam longint RUN_LIMIT = 600000;
    localparam bit [63:0] OFFSET_CAP = 64'd1 << 40;
    localparam bit [63:0] UNIT_MSB = 64'd1 << 30;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        status_t            st;
    } screen_pt_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [95:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Camera registers as the predictor sees them
    bit [31:0] cam_origin [3];
    bit [31:0] cam_axis [3];
    bit [47:0] cam_tan;
    bit [31:0] cam_dims;

    screen_pt_t pending_pts[$];
    int         n_errors;
    longint     cycle_cnt = 0;
    int         send_idle_pct;
    int         recv_stall_pct;

    world_to_screen_projection_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- projection predictor ----------------
    function automatic bit [63:0] abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        bit [63:0] m;
        m = (abs64(v) + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic bit [63:0] floor_sqrt(input bit [63:0] x);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Normalize a vector of n components to Q2.30
    function automatic void normalize(input longint v[3], input int n, output longint u[3]);
        bit [63:0] mg [3];
        bit [63:0] m;
        bit [63:0] sq;
        bit [63:0] r;
        bit [63:0] q;
        int s;
        m = 0;
        sq = 0;
        s = 0;
        for (int i = 0; i < 3; i++) u[i] = 0;
        for (int i = 0; i < n; i++) begin
            mg[i] = abs64(v[i]);
            if (mg[i] > m) m = mg[i];
        end
        if (m == 0) return;
        while (m < UNIT_MSB) begin
            m = m << 1;
            s++;
        end
        for (int i = 0; i < n; i++) begin
            mg[i] = mg[i] << s;
            sq = sq + mg[i] * mg[i];
        end
        r = floor_sqrt(sq);
        for (int i = 0; i < n; i++) begin
            q = ((mg[i] << UNIT_BITS) + r / 2) / r;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic longint dot_unit(input longint a[3], input longint b[3]);
        longint acc;
        acc = 0;
        for (int i = 0; i < 3; i++) acc = acc + a[i] * b[i];
        return round_shift(acc, UNIT_BITS);
    endfunction

    // Map one camera coordinate about the screen center
    function automatic logic signed [31:0] to_screen(input bit [63:0] dim, input bit [63:0] tn,
                                                     input longint v, input longint z,
                                                     input bit flip);
        longint ctr;
        longint res;
        bit [63:0] q;
        bit [63:0] d;
        bit [127:0] num;
        bit [127:0] qq;
        bit [127:0] rr;
        ctr = longint'(dim << (FRAC_BITS - 1));
        q = 0;
        if (v != 0) begin
            if (tn == 0) begin
                q = OFFSET_CAP;
            end else begin
                num = (128'(dim) << (FRAC_BITS - 1 + TAN_FRAC)) * 128'(abs64(v));
                d = tn * 64'(z);
                if (num[127:64] >= d) begin
                    q = OFFSET_CAP;
                end else begin
                    qq = num / 128'(d);
                    rr = num % 128'(d);
                    if (qq >= 128'(OFFSET_CAP)) q = OFFSET_CAP;
                    else q = qq[63:0] + ((rr[63:0] >= d - rr[63:0]) ? 64'd1 : 64'd0);
                end
            end
        end
        res = ((v < 0) != flip) ? ctr - longint'(q) : ctr + longint'(q);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res[31:0];
    endfunction

    function automatic screen_pt_t project_point(input bit [31:0] px, input bit [31:0] py,
                                                 input bit [31:0] pz);
        screen_pt_t o;
        longint ofs [3];
        longint ax [3];
        longint fw [3];
        longint rin [3];
        longint rt [3];
        longint up [3];
        longint cx;
        longint cy;
        longint cz;
        o.sx = 0;
        o.sy = 0;
        o.st = STAT_VISIBLE;
        if (cam_axis[0] == 0 && cam_axis[1] == 0) begin
            o.st = STAT_DEGEN;
            return o;
        end
        ofs[0] = longint'($signed(px)) - longint'($signed(cam_origin[0]));
        ofs[1] = longint'($signed(py)) - longint'($signed(cam_origin[1]));
        ofs[2] = longint'($signed(pz)) - longint'($signed(cam_origin[2]));
        for (int i = 0; i < 3; i++) ax[i] = longint'($signed(cam_axis[i]));
        normalize(ax, 3, fw);
        rin[0] = ax[1];
        rin[1] = -ax[0];
        rin[2] = 0;
        normalize(rin, 2, rt);
        up[0] = round_shift(rt[1] * fw[2], UNIT_BITS);
        up[1] = round_shift(-(rt[0] * fw[2]), UNIT_BITS);
        up[2] = round_shift(rt[0] * fw[1] - rt[1] * fw[0], UNIT_BITS);
        cx = dot_unit(ofs, rt);
        cy = dot_unit(ofs, up);
        cz = dot_unit(ofs, fw);
        if (cz < NEAR_VAL) begin
            o.st = STAT_NEAR;
            return o;
        end
        o.sx = to_screen(64'(cam_dims[31:16]), 64'(cam_tan[47:24]), cx, cz, 1'b0);
        o.sy = to_screen(64'(cam_dims[15:0]), 64'(cam_tan[23:0]), cy, cz, 1'b1);
        return o;
    endfunction

    // ---------------- drivers ----------------
    task automatic write_reg(input cfg_idx_t idx, input bit [47:0] val);
        // hold off until the pipeline has drained
        wait (pending_pts.size() == 0);
        repeat (60) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_ORIGIN_X:    cam_origin[0] = val[31:0];
            CFG_ORIGIN_Y:    cam_origin[1] = val[31:0];
            CFG_ORIGIN_Z:    cam_origin[2] = val[31:0];
            CFG_AXIS_X:      cam_axis[0] = val[31:0];
            CFG_AXIS_Y:      cam_axis[1] = val[31:0];
            CFG_AXIS_Z:      cam_axis[2] = val[31:0];
            CFG_TAN_HALF:    cam_tan = val;
            CFG_SCREEN_DIMS: cam_dims = val[31:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(input bit [31:0] ox, input bit [31:0] oy, input bit [31:0] oz,
                              input bit [31:0] ax, input bit [31:0] ay, input bit [31:0] az,
                              input bit [47:0] tn, input bit [31:0] dims);
        write_reg(CFG_ORIGIN_X, 48'(ox));
        write_reg(CFG_ORIGIN_Y, 48'(oy));
        write_reg(CFG_ORIGIN_Z, 48'(oz));
        write_reg(CFG_AXIS_X, 48'(ax));
        write_reg(CFG_AXIS_Y, 48'(ay));
        write_reg(CFG_AXIS_Z, 48'(az));
        write_reg(CFG_TAN_HALF, tn);
        write_reg(CFG_SCREEN_DIMS, 48'(dims));
    endtask

    // Called at a falling edge; returns at a falling edge
    task automatic send_point(input bit [31:0] px, input bit [31:0] py, input bit [31:0] pz);
        s_tvalid = 1'b1;
        s_tdata = {pz, py, px};
        do @(posedge aclk); while (!s_tready);
        pending_pts.push_back(project_point(px, py, pz));
        @(negedge aclk);
        s_tvalid = 1'b0;
        // idle each following cycle with the configured probability
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
    endtask

    // Random receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result with the oldest prediction
    always @(posedge aclk) begin
        screen_pt_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pts.size() == 0) begin
                $error("unexpected result sx=%h sy=%h status=%0d", m_tdata[31:0],
                       m_tdata[63:32], m_tuser);
                n_errors++;
            end else begin
                e = pending_pts.pop_front();
                if (m_tdata[31:0] !== e.sx) begin
                    $error("screen_x expected %h actual %h", e.sx, m_tdata[31:0]);
                    n_errors++;
                end
                if (m_tdata[63:32] !== e.sy) begin
                    $error("screen_y expected %h actual %h", e.sy, m_tdata[63:32]);
                    n_errors++;
                end
                if (m_tuser !== e.st) begin
                    $error("status expected %0d actual %0d", e.st, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_default_view();
        // default camera looks along +x from the origin
        send_point(32'h0001_0000, 32'h0, 32'h0);
        send_point(32'h000A_0000, 32'h0003_0000, 32'hFFFE_0000);
        send_point(32'h0000_199A, 32'h0000_0100, 32'h0);   // just past near plane
        send_point(32'h0000_1999, 32'h0, 32'h0);           // just short of it
        send_point(32'hFFF0_0000, 32'h0, 32'h0);           // behind
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0000_199A, 32'h7FFF_FFFF, 32'h8000_0000); // huge offset
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    endtask

    task automatic test_degenerate_axis();
        set_camera(0, 0, 0, 0, 0, 32'h0001_0000, 48'h0001_0000_0000, 32'h0780_0438);
        send_point(32'h0005_0000, 32'h0001_0000, 32'h0003_0000);
        write_reg(CFG_AXIS_Z, 0);
        send_point(32'hFFFF_FFFF, 32'h0, 32'h1234_5678);
    endtask

    task automatic test_zero_tangent();
        set_camera(0, 0, 0, 32'h0002_0000, 32'h0001_0000, 32'h8000_0000, 48'h0, 32'hFFFF_FFFF);
        send_point(32'h0010_0000, 32'h0003_0000, 32'hFFF0_0000);
        send_point(32'h0010_0000, 32'hFFFB_0000, 32'h0001_0000);
        send_point(32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000);
    endtask

    task automatic test_extremes();
        set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0, 32'h0, 32'h0);
        set_camera(32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0,
                   48'h0000_0100_0001, 32'hFFFF_0001);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    endtask

    function automatic bit [31:0] near_coord(input bit [31:0] base);
        if ($urandom_range(3) == 0) return $urandom;
        return base + 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
    endfunction

    task automatic random_camera();
        bit [31:0] ax;
        bit [31:0] ay;
        bit [47:0] tn;
        ax = ($urandom_range(1) == 0) ? $urandom : 32'($signed($urandom_range(0, 32'h40000))
                                                      - 32'sh20000);
        ay = ($urandom_range(1) == 0) ? $urandom : 32'($signed($urandom_range(0, 32'h40000))
                                                      - 32'sh20000);
        if ($urandom_range(9) == 0) begin
            ax = 0;
            ay = 0;
        end
        tn = {24'($urandom_range(32'h3000, 32'h40000)), 24'($urandom_range(32'h3000, 32'h40000))};
        if ($urandom_range(7) == 0) tn = {$urandom, 16'($urandom)};
        set_camera(($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 32'h1FFFFF)),
                   ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 32'h1FFFFF)),
                   ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 32'h1FFFFF)),
                   ax, ay, ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(0, 32'h10000)),
                   tn, ($urandom_range(5) == 0) ? $urandom
                       : {16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096))});
    endtask

    task automatic test_random_stream();
        int idle_mode [4][2] = '{'{0, 0}, '{71, 0}, '{0, 71}, '{19, 19}};
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = idle_mode[ph % 4][0];
            recv_stall_pct = idle_mode[ph % 4][1];
            random_camera();
            for (int n = 0; n < 115; n++) begin
                send_point(near_coord(cam_origin[0]), near_coord(cam_origin[1]),
                           near_coord(cam_origin[2]));
                // drain everything once mid-phase
                if (ph == 2 && n == 50) wait (pending_pts.size() == 0);
            end
        end
    endtask

    initial begin
        n_errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_ORIGIN_X;
        cfg_data = '0;
        cam_origin = '{0, 0, 0};
        cam_axis = '{32'h0001_0000, 0, 0};
        cam_tan = 48'h0001_0001_0000;
        cam_dims = 32'h0780_0438;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_default_view();
        test_degenerate_axis();
        test_zero_tangent();
        test_extremes();
        test_random_stream();

        wait (pending_pts.size() == 0);
        repeat (100) @(posedge aclk);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/wsp_pkg.sv
rtl/wsp_basis.sv
rtl/world_to_screen_projection_top.sv
dv/world_to_screen_projection_top_tb.sv
